### rtl/software_timer_queue_core_assert.svh
// Assertion macros shared by the timer queue RTL.
// Depends on nothing; included by the top level only.
`ifndef SOFTWARE_TIMER_QUEUE_CORE_ASSERT_SVH
`define SOFTWARE_TIMER_QUEUE_CORE_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define STQ_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked in the cycle after the antecedent.
`define STQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/stq_pkg.sv
// Shared types and constants for the timer queue.
// No dependencies; imported by every module of the block.
package stq_pkg;

    localparam int TIMER_SLOTS = 16;
    localparam int TIME_BITS   = 48;
    localparam int MAX_RESULTS = 16;
    localparam int SLOT_BITS   = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam int CNT_BITS    = $clog2(MAX_RESULTS + 1);
    localparam int HANDLE_BITS = 31;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_CANCEL = 2'd1,
        CMD_TICK   = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_ADDED     = 3'd0,
        ST_FULL      = 3'd1,
        ST_CANCELLED = 3'd2,
        ST_NOTFOUND  = 3'd3,
        ST_FIRED     = 3'd4,
        ST_NONE      = 3'd5,
        ST_CLEARED   = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_FLUSH,
        S_EMIT,
        S_WAIT
    } state_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic    load;       // capture input beat
        logic    do_add;     // store timer in free slot, bump counters
        logic    do_clear;   // drop all valid bits
        logic    scan_start; // reset the best-candidate search
        logic    scan_step;  // look at one slot
        logic    kill_best;  // invalidate the chosen slot, hold its handle
        logic    out_load;   // load output register
        status_t out_status;
        logic    out_use_pend;  // handle of the held firing
        logic    out_use_req;   // handle from request
        logic    out_use_next;  // handle from next_handle
        logic    out_last;
    } stq_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        cmd_t  cmd;
        logic  full;
        logic  scan_done;
        logic  found;
        logic  [CNT_BITS-1:0] fired;
        logic  out_busy;
    } stq_stat_t;

endpackage

### rtl/stq_datapath.sv
// Datapath of the timer queue: slot storage, time, handles, search, output register.
// Depends on stq_pkg.
module stq_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  stq_pkg::stq_cmd_t   ctl,
    output stq_pkg::stq_stat_t  stat,
    input  logic [96:0]         in_data,
    input  logic                cfg_valid,
    input  logic [30:0]         cfg_data,
    output logic [2:0]          out_status,
    output logic [30:0]         out_handle,
    output logic                out_last,
    output logic                out_valid,
    input  logic                out_ready
);
    import stq_pkg::*;

    logic [TIME_BITS-1:0]   dl_reg [TIMER_SLOTS];
    logic [HANDLE_BITS-1:0] hd_reg [TIMER_SLOTS];
    logic [31:0]            ord_reg [TIMER_SLOTS];
    logic [TIMER_SLOTS-1:0] valid_reg;

    logic [TIME_BITS-1:0]   now_reg;
    logic [HANDLE_BITS-1:0] next_handle_reg;
    logic [31:0]            ins_reg;

    cmd_t                   cmd_reg;
    logic [31:0]            arg_reg;
    logic [HANDLE_BITS-1:0] req_reg;

    logic [SLOT_BITS-1:0]   idx_reg;
    logic                   scan_done_reg;
    logic                   found_reg;
    logic [SLOT_BITS-1:0]   best_reg;
    logic [CNT_BITS-1:0]    fired_reg;
    logic [HANDLE_BITS-1:0] pend_reg;

    logic                   ov_reg;
    logic [2:0]             os_reg;
    logic [HANDLE_BITS-1:0] oh_reg;
    logic                   ol_reg;

    // Free slot: lowest invalid index.
    logic [SLOT_BITS-1:0] free_idx;
    logic                 full;
    always_comb
    begin
        free_idx = '0;
        full     = 1'b1;
        for (int i = TIMER_SLOTS - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_idx = SLOT_BITS'(i);
                full     = 1'b0;
            end
        end
    end

    // Saturating add of a 32-bit amount to the time base.
    function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] a,
                                                    input logic [31:0] b);
        logic [TIME_BITS:0] s;
        begin
            s = {1'b0, a} + {{(TIME_BITS - 31){1'b0}}, b};
            sat_add = s[TIME_BITS] ? {TIME_BITS{1'b1}} : s[TIME_BITS-1:0];
        end
    endfunction

    // Candidate test for the slot under the scan pointer.
    logic cand;
    logic better;
    logic [31:0] age_c;
    logic [31:0] age_b;
    always_comb
    begin
        if (cmd_reg == CMD_CANCEL)
            cand = valid_reg[idx_reg] && (hd_reg[idx_reg] == req_reg);
        else
            cand = valid_reg[idx_reg] && (dl_reg[idx_reg] < now_reg);
        age_c = ins_reg - ord_reg[idx_reg];
        age_b = ins_reg - ord_reg[best_reg];
        if (dl_reg[idx_reg] != dl_reg[best_reg])
            better = dl_reg[idx_reg] < dl_reg[best_reg];
        else
            better = age_c > age_b;
    end

    // Slot storage.
    always_ff @(posedge clk)
    begin
        if (ctl.do_add && !full)
        begin
            dl_reg[free_idx]  <= sat_add(now_reg, arg_reg);
            hd_reg[free_idx]  <= next_handle_reg;
            ord_reg[free_idx] <= ins_reg;
        end
    end

    // Control state of the datapath.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg       <= '0;
            now_reg         <= '0;
            next_handle_reg <= '0;
            ins_reg         <= '0;
            cmd_reg         <= CMD_ADD;
            idx_reg         <= '0;
            scan_done_reg   <= 1'b0;
            found_reg       <= 1'b0;
            best_reg        <= '0;
            fired_reg       <= '0;
            ov_reg          <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                next_handle_reg <= cfg_data;
            if (ctl.load)
            begin
                cmd_reg   <= cmd_t'(in_data[1:0]);
                fired_reg <= '0;
                if (cmd_t'(in_data[1:0]) == CMD_TICK)
                    now_reg <= sat_add(now_reg, in_data[96:65]);
            end
            if (ctl.do_add && !full)
            begin
                valid_reg[free_idx] <= 1'b1;
                ins_reg             <= ins_reg + 32'd1;
                next_handle_reg     <= next_handle_reg + 31'd1;
            end
            if (ctl.do_clear)
                valid_reg <= '0;
            if (ctl.scan_start)
            begin
                idx_reg       <= '0;
                scan_done_reg <= 1'b0;
                found_reg     <= 1'b0;
            end
            else if (ctl.scan_step)
            begin
                if (cand && (!found_reg || better))
                begin
                    best_reg  <= idx_reg;
                    found_reg <= 1'b1;
                end
                if (idx_reg == SLOT_BITS'(TIMER_SLOTS - 1))
                    scan_done_reg <= 1'b1;
                else
                    idx_reg <= idx_reg + SLOT_BITS'(1);
            end
            if (ctl.kill_best)
            begin
                valid_reg[best_reg] <= 1'b0;
                if (cmd_reg == CMD_TICK)
                    fired_reg <= fired_reg + CNT_BITS'(1);
            end
            if (ctl.out_load)
                ov_reg <= 1'b1;
            else if (out_ready)
                ov_reg <= 1'b0;
        end
    end

    // Capture of the request arguments, the held firing and the output payload.
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            arg_reg <= in_data[33:2];
            req_reg <= in_data[64:34];
        end
        if (ctl.kill_best)
            pend_reg <= hd_reg[best_reg];
        if (ctl.out_load)
        begin
            os_reg <= ctl.out_status;
            ol_reg <= ctl.out_last;
            if (ctl.out_use_pend)
                oh_reg <= pend_reg;
            else if (ctl.out_use_req)
                oh_reg <= req_reg;
            else if (ctl.out_use_next)
                oh_reg <= next_handle_reg;
            else
                oh_reg <= '0;
        end
    end

    assign stat.cmd       = cmd_reg;
    assign stat.full      = full;
    assign stat.scan_done = scan_done_reg;
    assign stat.found     = found_reg;
    assign stat.fired     = fired_reg;
    assign stat.out_busy  = ov_reg && !out_ready;

    assign out_valid  = ov_reg;
    assign out_status = os_reg;
    assign out_handle = oh_reg;
    assign out_last   = ol_reg;
endmodule

### rtl/stq_ctrl.sv
// Controller state machine of the timer queue.
// Depends on stq_pkg; drives stq_datapath through command signals.
module stq_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_fire,
    output logic               in_ready,
    input  stq_pkg::stq_stat_t stat,
    output stq_pkg::stq_cmd_t  ctl
);
    import stq_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        ctl.out_status = ST_ADDED;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_fire)
                begin
                    ctl.load       = 1'b1;
                    ctl.scan_start = 1'b1;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (stat.cmd == CMD_ADD || stat.cmd == CMD_CLEAR)
                    state_next = S_EMIT;
                else if (stat.scan_done)
                    state_next = S_DECIDE;
                else
                    ctl.scan_step = 1'b1;
            end
            S_DECIDE:
            begin
                // Wait until the output register is free.
                if (!stat.out_busy)
                begin
                    ctl.out_load = 1'b1;
                    if (stat.cmd == CMD_CANCEL)
                    begin
                        ctl.out_use_req = 1'b1;
                        ctl.out_last    = 1'b1;
                        ctl.out_status  = stat.found ? ST_CANCELLED : ST_NOTFOUND;
                        ctl.kill_best   = stat.found;
                        state_next      = S_WAIT;
                    end
                    else if (stat.found)
                    begin
                        // A new firing is held; the one held before it goes out, not last.
                        ctl.out_load     = (stat.fired != '0);
                        ctl.out_use_pend = 1'b1;
                        ctl.out_status   = ST_FIRED;
                        ctl.kill_best    = 1'b1;
                        if (stat.fired == CNT_BITS'(MAX_RESULTS - 1))
                            state_next = S_FLUSH;
                        else
                        begin
                            ctl.scan_start = 1'b1;
                            state_next     = S_SCAN;
                        end
                    end
                    else if (stat.fired == '0)
                    begin
                        ctl.out_status = ST_NONE;
                        ctl.out_last   = 1'b1;
                        state_next     = S_WAIT;
                    end
                    else
                    begin
                        // Nothing more is due, so the held firing is the last one.
                        ctl.out_use_pend = 1'b1;
                        ctl.out_status   = ST_FIRED;
                        ctl.out_last     = 1'b1;
                        state_next       = S_WAIT;
                    end
                end
            end
            S_FLUSH:
            begin
                // The firing limit is reached: send the held firing as the last one.
                if (!stat.out_busy)
                begin
                    ctl.out_load     = 1'b1;
                    ctl.out_use_pend = 1'b1;
                    ctl.out_status   = ST_FIRED;
                    ctl.out_last     = 1'b1;
                    state_next       = S_WAIT;
                end
            end
            S_EMIT:
            begin
                if (!stat.out_busy)
                begin
                    ctl.out_load = 1'b1;
                    ctl.out_last = 1'b1;
                    if (stat.cmd == CMD_CLEAR)
                    begin
                        ctl.do_clear   = 1'b1;
                        ctl.out_status = ST_CLEARED;
                    end
                    else if (stat.full)
                        ctl.out_status = ST_FULL;
                    else
                    begin
                        ctl.do_add       = 1'b1;
                        ctl.out_use_next = 1'b1;
                        ctl.out_status   = ST_ADDED;
                    end
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                if (!stat.out_busy)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end
endmodule

### rtl/software_timer_queue_core.sv
// Top level of the timer queue: ties the controller and datapath to the stream ports.
// Depends on stq_pkg, stq_ctrl, stq_datapath and the assertion macro header.
//
// Usage:
//   Commands arrive on s_axis (add, cancel, tick, clear), one beat each.
//   Results leave on m_axis; tlast marks the final result of a command.
//   The first_handle register is written on the cfg channel; cfg_ready is
//   high only while the block is idle.
//   Add and clear give one result from S_EMIT, after one pass through S_SCAN.
//   Cancel walks all TIMER_SLOTS slots, one per cycle.
//   A tick runs one slot walk per fired timer. A firing
//   is held until the next walk shows whether another follows, so the first
//   result leaves after two walks and each later one a walk apart; the
//   sixteenth goes out from S_FLUSH with no further walk. A tick with nothing
//   due answers after one walk.
//   One command is in flight at a time; s_axis_tready rises the cycle after
//   the final result beat is taken. The slot walk sets the rate.
//   A stalled m_axis holds the result register; the controller waits before
//   the next result until the beat is taken.
//   Reset clears time, counters, the handle register and all valid bits.
`include "software_timer_queue_core_assert.svh"
module software_timer_queue_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,  // delay[31:0], handle[62:32], elapsed[94:63], zero fill
    input  logic [1:0]  s_axis_tuser,  // cmd[1:0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [30:0] cfg_data,      // first_handle
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // handle_out[30:0], zero fill
    output logic [2:0]  m_axis_tuser,  // status[2:0]
    output logic        m_axis_tlast   // last
);
    import stq_pkg::*;

    // Datapath request word, low bit up: cmd, delay, handle, elapsed.
    stq_cmd_t  ctl;
    stq_stat_t stat;
    logic [96:0]  dp_in;
    logic [2:0]   st;
    logic [30:0]  ho;

    assign dp_in = {s_axis_tdata[94:0], s_axis_tuser};
    assign cfg_ready = s_axis_tready;

    stq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (s_axis_tvalid && s_axis_tready),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .ctl      (ctl)
    );

    stq_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .stat       (stat),
        .in_data    (dp_in),
        .cfg_valid  (cfg_valid && cfg_ready),
        .cfg_data   (cfg_data),
        .out_status (st),
        .out_handle (ho),
        .out_last   (m_axis_tlast),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready)
    );

    assign m_axis_tdata = {1'b0, ho};
    assign m_axis_tuser = st;

    `STQ_ASSERT_IMP(a_idle_no_result, s_axis_tready, !m_axis_tvalid,
        "result pending while the block accepts a command")
    `STQ_ASSERT_NEXT(a_no_accept_busy, s_axis_tvalid && s_axis_tready, !s_axis_tready,
        "second beat accepted while a command is in flight")
    `STQ_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast),
        "result beat changed while stalled")
endmodule
